// ----- rtl/wms_pkg.sv -----
// Shared constants and types for the streaming window minimizer.
package wms_pkg;

    // Default window and substring lengths.
    localparam int K_LEN_DEF = 15;
    localparam int M_LEN_DEF = 5;

    // Fixed field widths.
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 40;
    localparam int POS_W   = 32;

    // Control that travels with a window waiting for evaluation.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic [POS_W-1:0] wstart;
    } win_ctrl_t;

endpackage

// ----- rtl/wms_window.sv -----
// Input stage: character shift register, fill counter and position counter.
module wms_window
    import wms_pkg::*;
#(
    parameter int K_LEN = K_LEN_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [CHAR_W-1:0]       base_char,
    input  logic                    seq_start,
    input  logic                    advance,
    output logic [K_LEN*CHAR_W-1:0] window,
    output win_ctrl_t               ctrl
);

    localparam int FILL_W = $clog2(K_LEN + 1);

    logic [K_LEN*CHAR_W-1:0] window_reg;
    logic [K_LEN*CHAR_W-1:0] window_next;
    logic [FILL_W-1:0]       fill_reg;
    logic [FILL_W-1:0]       fill_next;
    logic [POS_W-1:0]        pos_reg;
    logic [POS_W-1:0]        pos_next;
    win_ctrl_t               ctrl_reg;
    win_ctrl_t               ctrl_next;

    logic              accept;
    logic [FILL_W-1:0] fill_base;
    logic [POS_W-1:0]  pos_base;

    // A pending window must move on before the shift register may change.
    assign in_stall = ctrl_reg.valid && !advance;
    assign accept   = in_valid && !in_stall;

    // Next state for the counters, the window and the pending flag.
    always_comb
    begin
        fill_base   = seq_start ? '0 : fill_reg;
        pos_base    = seq_start ? '0 : pos_reg;
        window_next = window_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        ctrl_next   = ctrl_reg;
        if (accept)
        begin
            // Oldest character sits in the lowest byte.
            window_next = {base_char, window_reg[K_LEN*CHAR_W-1:CHAR_W]};
            pos_next    = pos_base + POS_W'(1);
            fill_next   = (fill_base < FILL_W'(K_LEN)) ? fill_base + FILL_W'(1) : fill_base;
            ctrl_next.valid  = (fill_base >= FILL_W'(K_LEN - 1));
            ctrl_next.first  = (fill_base == FILL_W'(K_LEN - 1));
            ctrl_next.wstart = pos_base - POS_W'(K_LEN - 1);
        end
        else if (advance)
        begin
            ctrl_next.valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pos_reg  <= '0;
            ctrl_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
            ctrl_reg <= ctrl_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

    assign window = window_reg;
    assign ctrl   = ctrl_reg;

endmodule

// ----- rtl/wms_min_tree.sv -----
// Comparator tree that finds the leftmost smallest substring of a window.
module wms_min_tree
    import wms_pkg::*;
#(
    parameter int K_LEN = K_LEN_DEF,
    parameter int M_LEN = M_LEN_DEF
)
(
    input  logic [K_LEN*CHAR_W-1:0] window,
    output logic [M_LEN*CHAR_W-1:0] best_key,
    output logic [POS_W-1:0]        best_offset
);

    localparam int KEY_W   = M_LEN * CHAR_W;
    localparam int NUM_SUB = (K_LEN >= M_LEN) ? (K_LEN - M_LEN + 1) : 1;
    localparam int LVLS    = $clog2(NUM_SUB);
    localparam int LEAVES  = 1 << LVLS;
    localparam int NODES   = 2 * LEAVES - 1;
    localparam int IDX_W   = (NUM_SUB > 1) ? $clog2(NUM_SUB) : 1;

    // Heap-ordered nodes: node n has children 2n+1 (left) and 2n+2 (right).
    logic [KEY_W-1:0] node_key [NODES];
    logic [IDX_W-1:0] node_idx [NODES];
    logic             node_ok  [NODES];

    // Leaves: one packed substring each; positions past the window read as zero.
    for (genvar i = 0; i < LEAVES; i++)
    begin : g_leaf
        if (i < NUM_SUB)
        begin : g_used
            for (genvar j = 0; j < M_LEN; j++)
            begin : g_byte
                if (i + j < K_LEN)
                begin : g_in
                    assign node_key[LEAVES-1+i][(M_LEN-1-j)*CHAR_W +: CHAR_W] =
                        window[(i+j)*CHAR_W +: CHAR_W];
                end
                else
                begin : g_pad
                    assign node_key[LEAVES-1+i][(M_LEN-1-j)*CHAR_W +: CHAR_W] = '0;
                end
            end
            assign node_idx[LEAVES-1+i] = IDX_W'(i);
            assign node_ok[LEAVES-1+i]  = 1'b1;
        end
        else
        begin : g_empty
            assign node_key[LEAVES-1+i] = '0;
            assign node_idx[LEAVES-1+i] = '0;
            assign node_ok[LEAVES-1+i]  = 1'b0;
        end
    end

    // Internal nodes: the right child wins only when strictly smaller.
    for (genvar n = 0; n < LEAVES - 1; n++)
    begin : g_node
        logic take_right;
        assign take_right = node_ok[2*n+2] &&
                            (!node_ok[2*n+1] || (node_key[2*n+2] < node_key[2*n+1]));
        assign node_key[n] = take_right ? node_key[2*n+2] : node_key[2*n+1];
        assign node_idx[n] = take_right ? node_idx[2*n+2] : node_idx[2*n+1];
        assign node_ok[n]  = node_ok[2*n+1] || node_ok[2*n+2];
    end

    assign best_key    = node_key[0];
    assign best_offset = POS_W'(node_idx[0]);

endmodule

// ----- rtl/window_minimizer_stream_top.sv -----
// A character is registered in the input stage's shift register; the comparator
// tree evaluates its window into the result register. Throughput: one character
// per cycle while in_stall is low; the input stage and the result register each
// hold one item, and the window minimum is one comparator tree between them.
// Reset (rst_n, asynchronous, active low) clears counters, pending, the previous
// minimum and output valid; the character shift register needs no clearing.
module window_minimizer_stream_top
    import wms_pkg::*;
#(
    parameter int K_LEN = K_LEN_DEF,
    parameter int M_LEN = M_LEN_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CHAR_W-1:0]   base_char,
    input  logic                seq_start,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [VALUE_W-1:0]  minimizer_value,
    output logic [POS_W-1:0]    window_start,
    output logic [POS_W-1:0]    minimizer_position
);

    localparam int KEY_W   = M_LEN * CHAR_W;
    localparam int NUM_SUB = (K_LEN >= M_LEN) ? (K_LEN - M_LEN + 1) : 1;

    logic [K_LEN*CHAR_W-1:0] window;
    win_ctrl_t               win_ctrl;
    logic                    advance;
    logic [KEY_W-1:0]        best_key;
    logic [POS_W-1:0]        best_offset;
    logic [VALUE_W-1:0]      shown;
    logic                    emit;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic [POS_W-1:0]   wstart_reg;
    logic [POS_W-1:0]   wstart_next;
    logic [POS_W-1:0]   mpos_reg;
    logic [POS_W-1:0]   mpos_next;
    logic [VALUE_W-1:0] prev_min_reg;
    logic [VALUE_W-1:0] prev_min_next;

    // The pending window moves on when the result register is free or being taken.
    assign advance = !out_valid_reg || !out_stall;

    wms_window #(
        .K_LEN (K_LEN)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .base_char (base_char),
        .seq_start (seq_start),
        .advance   (advance),
        .window    (window),
        .ctrl      (win_ctrl)
    );

    wms_min_tree #(
        .K_LEN (K_LEN),
        .M_LEN (M_LEN)
    ) u_min_tree (
        .window      (window),
        .best_key    (best_key),
        .best_offset (best_offset)
    );

    // Only the low 40 bits of the minimizer are reported and compared.
    if (KEY_W >= VALUE_W)
    begin : g_trim
        assign shown = best_key[VALUE_W-1:0];
    end
    else
    begin : g_extend
        assign shown = {{(VALUE_W-KEY_W){1'b0}}, best_key};
    end

    // First window of a sequence always reports; later ones only on a change.
    assign emit = win_ctrl.first || (shown != prev_min_reg);

    // Result register next state.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        wstart_next    = wstart_reg;
        mpos_next      = mpos_reg;
        prev_min_next  = prev_min_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (win_ctrl.valid && advance)
        begin
            prev_min_next = shown;
            if (emit)
            begin
                out_valid_next = 1'b1;
                value_next     = shown;
                wstart_next    = win_ctrl.wstart;
                mpos_next      = win_ctrl.wstart + best_offset;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prev_min_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            prev_min_reg  <= prev_min_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        wstart_reg <= wstart_next;
        mpos_reg   <= mpos_next;
    end

    assign out_valid          = out_valid_reg;
    assign minimizer_value    = value_reg;
    assign window_start       = wstart_reg;
    assign minimizer_position = mpos_reg;

    // The input side stalls only behind a window that is waiting to move on.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (win_ctrl.valid && !advance))
        else $error("input stalled without a blocked pending window");

    // The first window of a sequence always produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (win_ctrl.valid && win_ctrl.first && advance) |=> out_valid)
        else $error("first window of a sequence produced no result");

    // A new result only appears after a pending window was evaluated.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(win_ctrl.valid))
        else $error("result appeared without a pending window");

    // The minimizer lies inside the window's range of substring starts.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((minimizer_position - window_start) < POS_W'(NUM_SUB)))
        else $error("minimizer position outside the window");

endmodule
